FILE: hdl/tsps_pkg.sv
// Shared types and constants for the three-motor stepper position scheduler.
package tsps_pkg;

  localparam int NUM_LANES  = 3;
  localparam int POS_W      = 16;
  localparam int PHASE_W    = 4;
  localparam int INTERVAL_W = 8;
  localparam int CFG_IDX_W  = 2;

  // Item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MOTOR0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MOTOR1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MOTOR2 = 2'd2;

  // Step interval values after reset
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET [NUM_LANES] = '{8'd4, 8'd7, 8'd9};

  typedef struct packed {
    logic                    op;
    logic [1:0]              motor_select;
    logic signed [POS_W-1:0] target_position;
  } tsps_item_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] step_mask;
    logic [PHASE_W-1:0]   phase_motor0;
    logic [PHASE_W-1:0]   phase_motor1;
    logic [PHASE_W-1:0]   phase_motor2;
    logic [NUM_LANES-1:0] clockwise_mask;
    logic [NUM_LANES-1:0] running_mask;
    logic [NUM_LANES-1:0] homing_mask;
    logic                 clear_coils;
  } tsps_result_t;

  // Command from the top level to one motor lane
  typedef struct packed {
    logic                    tick;
    logic                    set;
    logic signed [POS_W-1:0] target;
  } tsps_cmd_t;

  // Status of one motor lane after the current transaction
  typedef struct packed {
    logic               stepped;
    logic [PHASE_W-1:0] phase;
    logic               clockwise;
    logic               running;
    logic               homing;
    logic               clear;
  } tsps_status_t;

endpackage

FILE: hdl/tsps_motor_lane.sv
// State and step logic for one stepper motor.
module tsps_motor_lane
  import tsps_pkg::*;
#(
  parameter int PHASE_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tsps_cmd_t             cmd,
  input  logic [INTERVAL_W-1:0] interval,
  output tsps_status_t          status
);

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);

  logic [POS_W-1:0]      position, position_next;
  logic [POS_W-1:0]      goal, goal_next;
  logic [PHASE_W-1:0]    phase, phase_next;
  logic                  clockwise, clockwise_next;
  logic                  running, running_next;
  logic                  homing, homing_next;
  logic [INTERVAL_W-1:0] divider, divider_next;

  logic [INTERVAL_W-1:0] limit;
  logic                  hit;
  logic [POS_W-1:0]      stepped_pos;
  logic                  stepped;
  logic                  clear;

  // Treat a zero interval as one
  assign limit = (interval == '0) ? INTERVAL_W'(1) : interval;
  assign hit   = ({1'b0, divider} + (INTERVAL_W+1)'(1)) >= {1'b0, limit};
  assign stepped_pos = clockwise ? position + POS_W'(1) : position - POS_W'(1);

  // Compute the state after this transaction
  always_comb begin
    position_next  = position;
    goal_next      = goal;
    phase_next     = phase;
    clockwise_next = clockwise;
    running_next   = running;
    homing_next    = homing;
    divider_next   = divider;
    stepped        = 1'b0;
    clear          = 1'b0;
    if (cmd.tick && running) begin
      if (hit) begin
        stepped       = 1'b1;
        divider_next  = '0;
        phase_next    = (phase == PHASE_LAST) ? '0 : phase + PHASE_W'(1);
        position_next = stepped_pos;
        if (stepped_pos == goal) begin
          running_next = 1'b0;
          if (homing) begin
            homing_next   = 1'b0;
            position_next = '0;
          end
        end
      end else begin
        divider_next = divider + INTERVAL_W'(1);
      end
    end else if (cmd.set) begin
      if (running || (cmd.target != $signed(position))) begin
        goal_next = cmd.target;
        if (cmd.target > $signed(position)) begin
          running_next   = 1'b1;
          clockwise_next = 1'b1;
        end else if (cmd.target < $signed(position)) begin
          running_next   = 1'b1;
          clear          = clockwise;
          clockwise_next = 1'b0;
        end else begin
          running_next = 1'b0;
          divider_next = '0;
        end
      end
    end
  end

  // Hold motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      goal      <= '0;
      phase     <= '0;
      clockwise <= 1'b1;
      running   <= 1'b0;
      homing    <= 1'b1;
      divider   <= '0;
    end else begin
      position  <= position_next;
      goal      <= goal_next;
      phase     <= phase_next;
      clockwise <= clockwise_next;
      running   <= running_next;
      homing    <= homing_next;
      divider   <= divider_next;
    end
  end

  assign status = '{stepped:   stepped,
                    phase:     phase_next,
                    clockwise: clockwise_next,
                    running:   running_next,
                    homing:    homing_next,
                    clear:     clear};

  // A stopped motor keeps its divider at zero
  a_idle_divider: assert property (@(posedge clk) disable iff (rst)
    !running |-> divider == '0)
    else $error("stopped motor has a nonzero divider");

  // A step advances the phase, unless there is only one phase
  a_step_phase: assert property (@(posedge clk) disable iff (rst)
    stepped |=> phase != $past(phase) || PHASE_COUNT == 1)
    else $error("step did not advance the phase");

endmodule

FILE: hdl/three_stepper_position_scheduler_core.sv
// Top level: three stepper motors driven toward target positions by tick and set transactions.
// Flow: an accepted item sits in the input register until the result register is free, where
//   its result is registered; each item updates the motor lanes in a single pass.
// Throughput: one item per cycle while the result side is not stalled by result_ready.
// Reset (rst, synchronous): intervals 4/7/9, positions, goals and phases zero, motors
//   stopped, clockwise and homing; no transaction pending on either channel.
module three_stepper_position_scheduler_core
  import tsps_pkg::*;
#(
  parameter int PHASE_COUNT = 8,
  parameter int MOTOR_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tsps_item_t            item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output tsps_result_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [INTERVAL_W-1:0] cfg_data
);

  logic [INTERVAL_W-1:0] interval [NUM_LANES];
  logic                  held_valid;
  tsps_item_t            held;
  logic                  advance;
  tsps_cmd_t             cmd    [NUM_LANES];
  tsps_status_t          status [NUM_LANES];
  tsps_result_t          result_next;

  assign cfg_ready  = 1'b1;
  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  // Write step interval registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTERVAL_MOTOR0: interval[0] <= cfg_data;
        CFG_INTERVAL_MOTOR1: interval[1] <= cfg_data;
        CFG_INTERVAL_MOTOR2: interval[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  // Motor lanes; lanes beyond the motor count read as zero
  for (genvar m = 0; m < NUM_LANES; m++) begin : g_lane
    assign cmd[m] = '{tick:   advance && (held.op == OP_TICK),
                      set:    advance && (held.op == OP_SET) && (held.motor_select == 2'(m)),
                      target: held.target_position};
    if (m < MOTOR_COUNT) begin : g_on
      tsps_motor_lane #(
        .PHASE_COUNT(PHASE_COUNT)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd[m]),
        .interval (interval[m]),
        .status   (status[m])
      );
    end else begin : g_off
      assign status[m] = '0;
    end
  end

  // Gather lane status into a result
  always_comb begin
    result_next              = '0;
    result_next.phase_motor0 = status[0].phase;
    result_next.phase_motor1 = status[1].phase;
    result_next.phase_motor2 = status[2].phase;
    for (int m = 0; m < NUM_LANES; m++) begin
      result_next.step_mask[m]      = status[m].stepped;
      result_next.clockwise_mask[m] = status[m].clockwise;
      result_next.running_mask[m]   = status[m].running;
      result_next.homing_mask[m]    = status[m].homing;
      result_next.clear_coils       = result_next.clear_coils | status[m].clear;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A reversal never coincides with a step
  a_clear_no_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clear_coils |-> result.step_mask == '0)
    else $error("clear_coils with a step in the same result");

  // A reversal leaves at least one motor counterclockwise
  a_clear_ccw: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clear_coils |-> result.clockwise_mask != '1)
    else $error("clear_coils while every motor is clockwise");

  // Absent motors never report activity
  a_absent_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.running_mask | result.step_mask) >> MOTOR_COUNT) == '0)
    else $error("absent motor reports activity");

  // A held item is kept while the result side stalls
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && result_valid && !result_ready |=> held_valid && $stable(held))
    else $error("held item lost during a stall");

endmodule
